FILE: rtl/core/hlva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hlva_pkg;

    // Field widths of the item and result ports.
    localparam int CMD_W   = 2;
    localparam int PIX_W   = 9;
    localparam int ANG_W   = 8;
    localparam int DIST_W  = 11;
    localparam int HALF_W  = 10;
    localparam int COUNT_W = 19;

    // Fixed geometry of the transform.
    localparam int ANGLE_STEPS = 180;
    localparam int MAX_DIM     = 512;
    localparam int QUARTER_DEG = 90;

    // Fixed-point arithmetic: Q1.16 trig words and the widths that follow.
    localparam int Q_FRAC = 16;
    localparam int TRIG_W = 17;
    localparam int MAG_W  = 7;
    localparam int PROD_W = PIX_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RHO_W  = SUM_W - Q_FRAC;
    localparam int J_W    = RHO_W + 1;
    localparam int CMP_W  = 16;

    localparam logic [HALF_W-1:0]  HALF_RESET = HALF_W'(724);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // Input command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_VOTE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd_code;

    // Work classes handed from the front to the back.
    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_VOTE  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [PIX_W-1:0]  pixel_x;
        logic [PIX_W-1:0]  pixel_y;
        logic [ANG_W-1:0]  angle_index;
        logic [DIST_W-1:0] distance_index;
    } t_work;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic               clipped;
    } t_result;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_VOTE,
        ST_DRAIN,
        ST_READ,
        ST_READ_WAIT,
        ST_RESULT
    } t_back_state;

    // sin(0..90 degrees) in Q1.16, rounded to nearest.
    localparam logic [TRIG_W-1:0] QUARTER_SIN [0:QUARTER_DEG] = '{
        17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,
        17'd5712,  17'd6850,  17'd7987,  17'd9121,  17'd10252,
        17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
        17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336,
        17'd22415, 17'd23486, 17'd24550, 17'd25607, 17'd26656,
        17'd27697, 17'd28729, 17'd29753, 17'd30767, 17'd31772,
        17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
        17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243,
        17'd42126, 17'd42995, 17'd43852, 17'd44695, 17'd45525,
        17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
        17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020,
        17'd53684, 17'd54332, 17'd54963, 17'd55578, 17'd56175,
        17'd56756, 17'd57319, 17'd57865, 17'd58393, 17'd58903,
        17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
        17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997,
        17'd63303, 17'd63589, 17'd63856, 17'd64104, 17'd64332,
        17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
        17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526,
        17'd65536
    };

endpackage

`default_nettype wire

FILE: rtl/core/hough_line_vote_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none

// Line Hough vote accumulator over 180 angles (-90 to 89 degrees) and
// DISTANCE_BINS distance bins. Items go in through push/full and each item
// gives exactly one result through empty/pop, in order. A vote of an edge
// pixel is taken from the work queue; its 180 angle steps then pass
// one per cycle through a read-increment-write loop on the store, which has
// one write port and one registered read port; the pipeline then drains and
// the result is handed over. A read and a vote that does not count skip the loop.
// A clear, and the sweep that follows reset, walk the whole store of
// 180 * 2**ceil(log2(DISTANCE_BINS)) counters one counter per cycle, 368640
// at the default size; full stays high during the sweep after reset. The
// rho_half_range register is written on the cfg channel, which is always
// ready, and must only change while the block is idle.
module hough_line_vote_accumulator #(
    parameter int DISTANCE_BINS = 2048
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [hlva_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [hlva_pkg::PIX_W-1:0]    i_pixel_x,
    input  wire logic [hlva_pkg::PIX_W-1:0]    i_pixel_y,
    input  wire logic                          i_is_edge,
    input  wire logic [hlva_pkg::ANG_W-1:0]    i_angle_index,
    input  wire logic [hlva_pkg::DIST_W-1:0]   i_distance_index,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [hlva_pkg::COUNT_W-1:0]       o_bin_count,
    output logic                               o_clipped,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [hlva_pkg::HALF_W-1:0]   i_cfg_data
);

    import hlva_pkg::*;

    logic [HALF_W-1:0] r_half;
    t_work             work;
    logic              work_valid;
    logic              work_pop;
    logic              init_busy;
    t_result           res_in;
    t_result           res_out;
    logic              res_push;
    logic              res_full;

    // Configuration register: every beat is taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half <= i_cfg_data;
        end
    end

    hlva_front #(
        .DISTANCE_BINS (DISTANCE_BINS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_cmd            (i_cmd),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_is_edge        (i_is_edge),
        .i_angle_index    (i_angle_index),
        .i_distance_index (i_distance_index),
        .i_init_busy      (init_busy),
        .i_work_pop       (work_pop),
        .o_work           (work),
        .o_work_valid     (work_valid)
    );

    hlva_back #(
        .DISTANCE_BINS (DISTANCE_BINS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_half       (r_half),
        .i_work_valid (work_valid),
        .i_work       (work),
        .o_work_pop   (work_pop),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_res_full   (res_full),
        .o_init_busy  (init_busy)
    );

    // Result queue toward the consumer.
    hlva_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_bin_count = res_out.bin_count;
    assign o_clipped   = res_out.clipped;

endmodule

`default_nettype wire

FILE: rtl/core/hlva_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module hlva_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hlva_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hlva_front #(
    parameter int DISTANCE_BINS = 2048
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [hlva_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [hlva_pkg::PIX_W-1:0]    i_pixel_x,
    input  wire logic [hlva_pkg::PIX_W-1:0]    i_pixel_y,
    input  wire logic                          i_is_edge,
    input  wire logic [hlva_pkg::ANG_W-1:0]    i_angle_index,
    input  wire logic [hlva_pkg::DIST_W-1:0]   i_distance_index,
    input  wire logic                          i_init_busy,
    input  wire logic                          i_work_pop,
    output hlva_pkg::t_work                    o_work,
    output logic                               o_work_valid
);

    import hlva_pkg::*;

    localparam int XW = CMP_W + DIST_W;

    t_work work;
    logic  q_full;
    logic  q_empty;
    logic  in_dim;
    logic  in_bins;

    // Range checks on the pixel position and the read address.
    assign in_dim  = (32'(i_pixel_x) < MAX_DIM) && (32'(i_pixel_y) < MAX_DIM);
    assign in_bins = (i_angle_index < ANG_W'(ANGLE_STEPS))
                  && (XW'(i_distance_index) < XW'(DISTANCE_BINS));

    // Sort each item into the kind of work the back end will do.
    always_comb begin
        work.pixel_x        = i_pixel_x;
        work.pixel_y        = i_pixel_y;
        work.angle_index    = i_angle_index;
        work.distance_index = i_distance_index;
        unique case (i_cmd)
            CMD_VOTE:  work.op = (i_is_edge && in_dim) ? OP_VOTE : OP_NOP;
            CMD_READ:  work.op = in_bins ? OP_READ : OP_NOP;
            CMD_CLEAR: work.op = OP_CLEAR;
            default:   work.op = OP_NOP;
        endcase
    end

    // The input side holds off while the store is swept after reset.
    assign o_full       = q_full || i_init_busy;
    assign o_work_valid = !q_empty;

    hlva_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (2)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  (work),
        .o_full  (q_full),
        .i_pop   (i_work_pop),
        .o_data  (o_work),
        .o_empty (q_empty)
    );

endmodule

`default_nettype wire

FILE: rtl/core/hlva_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hlva_back #(
    parameter int DISTANCE_BINS = 2048
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [hlva_pkg::HALF_W-1:0]   i_half,
    input  wire logic                          i_work_valid,
    input  hlva_pkg::t_work                    i_work,
    output logic                               o_work_pop,
    output logic                               o_res_push,
    output hlva_pkg::t_result                  o_res,
    input  wire logic                          i_res_full,
    output logic                               o_init_busy
);

    import hlva_pkg::*;

    localparam int BW        = (DISTANCE_BINS > 1) ? $clog2(DISTANCE_BINS) : 1;
    localparam int MW        = ANG_W + BW;
    localparam int MEM_DEPTH = ANGLE_STEPS * (2 ** BW);
    localparam logic [MW-1:0]    SWEEP_LAST = MW'(MEM_DEPTH - 1);
    localparam logic [CMP_W-1:0] BIN_LAST   = CMP_W'(DISTANCE_BINS - 1);
    localparam logic [ANG_W-1:0] STEP_LAST  = ANG_W'(ANGLE_STEPS - 1);
    localparam logic [ANG_W-1:0] STEP_ZERO  = ANG_W'(QUARTER_DEG);

    // Sequencer and current item.
    t_back_state       r_state;
    t_back_state       n_state;
    logic              r_init;
    logic [ANG_W-1:0]  r_step;
    logic [MW-1:0]     r_sweep;
    t_work             r_work;
    logic              r_clip;

    logic take_work;
    logic issue;
    logic sweep_on;
    logic read_issue;
    logic c_clip;

    // Angle pipeline.
    logic              r_a_valid;
    logic [ANG_W-1:0]  r_a_angle;
    logic [PROD_W-1:0] r_a_xc;
    logic [PROD_W-1:0] r_a_ys;
    logic              r_a_sneg;
    logic              r_b_valid;
    logic [ANG_W-1:0]  r_b_angle;
    logic signed [J_W-1:0] r_b_j;
    logic              r_c_valid;
    logic [MW-1:0]     r_rd_addr;
    logic              r_d_valid;
    logic [MW-1:0]     r_wr_addr;
    logic [COUNT_W-1:0] r_rd_data;

    logic [COUNT_W-1:0] r_mem [MEM_DEPTH];

    // ------------------------------------------------------------------
    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: begin
                if (r_sweep == SWEEP_LAST) begin
                    n_state = r_init ? ST_IDLE : ST_RESULT;
                end
            end
            ST_IDLE: begin
                if (i_work_valid) begin
                    unique case (i_work.op)
                        OP_VOTE:  n_state = ST_VOTE;
                        OP_READ:  n_state = ST_READ;
                        OP_CLEAR: n_state = ST_SWEEP;
                        OP_NOP:   n_state = ST_RESULT;
                    endcase
                end
            end
            ST_VOTE: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!(r_a_valid || r_b_valid || r_c_valid || r_d_valid)) begin
                    n_state = ST_RESULT;
                end
            end
            ST_READ:      n_state = ST_READ_WAIT;
            ST_READ_WAIT: n_state = ST_RESULT;
            ST_RESULT: begin
                if (!i_res_full) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        take_work  = 1'b0;
        issue      = 1'b0;
        sweep_on   = 1'b0;
        read_issue = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            ST_SWEEP:     sweep_on   = 1'b1;
            ST_IDLE:      take_work  = i_work_valid;
            ST_VOTE:      issue      = 1'b1;
            ST_READ:      read_issue = 1'b1;
            ST_RESULT:    o_res_push = !i_res_full;
            ST_DRAIN, ST_READ_WAIT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_work_pop  = take_work;
    assign o_init_busy = r_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    // Step, sweep and flag registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= 1'b1;
            r_step  <= '0;
            r_sweep <= '0;
            r_clip  <= 1'b0;
        end else begin
            if (take_work) begin
                r_step  <= '0;
                r_sweep <= '0;
                r_clip  <= 1'b0;
            end else begin
                if (issue) begin
                    r_step <= r_step + 1'b1;
                end
                if (sweep_on) begin
                    r_sweep <= r_sweep + 1'b1;
                end
                // The clamp flag belongs to the step that sits in stage C.
                if (r_b_valid && c_clip) begin
                    r_clip <= 1'b1;
                end
            end
            if (sweep_on && (r_sweep == SWEEP_LAST)) begin
                r_init <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_work) begin
            r_work <= i_work;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: trig lookup for the angle and the two products.
    logic             a_neg;
    logic [ANG_W-1:0] a_mag_full;
    logic [MAG_W-1:0] a_mag;
    logic [TRIG_W-1:0] a_cos;
    logic [TRIG_W-1:0] a_sin;

    always_comb begin
        a_neg      = (r_step < STEP_ZERO);
        a_mag_full = a_neg ? (STEP_ZERO - r_step) : (r_step - STEP_ZERO);
        a_mag      = a_mag_full[MAG_W-1:0];
        a_cos      = QUARTER_SIN[MAG_W'(QUARTER_DEG) - a_mag];
        a_sin      = QUARTER_SIN[a_mag];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_angle <= r_step;
        r_a_sneg  <= a_neg;
        r_a_xc    <= PROD_W'(r_work.pixel_x) * PROD_W'(a_cos);
        r_a_ys    <= PROD_W'(r_work.pixel_y) * PROD_W'(a_sin);
    end

    // ------------------------------------------------------------------
    // Stage B: signed sum, ceiling to an integer rho, add the half range.
    logic signed [SUM_W-1:0] b_xc;
    logic signed [SUM_W-1:0] b_ys;
    logic signed [SUM_W-1:0] b_sum;
    logic signed [SUM_W-1:0] b_up;
    logic signed [RHO_W-1:0] b_rho;
    logic signed [J_W-1:0]   b_j;

    always_comb begin
        b_xc  = $signed({2'b00, r_a_xc});
        b_ys  = $signed({2'b00, r_a_ys});
        b_sum = r_a_sneg ? (b_xc - b_ys) : (b_xc + b_ys);
        // Adding one less than a unit before the arithmetic shift gives the ceiling.
        b_up  = b_sum + $signed(SUM_W'((1 << Q_FRAC) - 1));
        b_rho = b_up[Q_FRAC +: RHO_W];
        b_j   = $signed({b_rho[RHO_W-1], b_rho})
              + $signed({{(J_W - HALF_W){1'b0}}, i_half});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_angle <= r_a_angle;
        r_b_j     <= b_j;
    end

    // ------------------------------------------------------------------
    // Stage C: clamp to the bin range and form the store address.
    logic [CMP_W-1:0] c_top2;
    logic [CMP_W-1:0] c_top;
    logic [CMP_W-1:0] c_j;
    logic [CMP_W-1:0] c_bin_w;
    logic [MW-1:0]    c_addr;
    logic [BW+DIST_W-1:0] rd_di_ext;
    logic [MW-1:0]    rd_addr;
    logic [MW-1:0]    n_rd_addr;

    always_comb begin
        c_top2 = CMP_W'({i_half, 1'b0});
        c_top  = (c_top2 > BIN_LAST) ? BIN_LAST : c_top2;
        c_j    = CMP_W'(r_b_j);
        c_clip = 1'b0;
        if (r_b_j[J_W-1]) begin
            c_bin_w = '0;
        end else if (c_j > c_top) begin
            c_bin_w = c_top;
            c_clip  = 1'b1;
        end else begin
            c_bin_w = c_j;
        end
        c_addr = {r_b_angle, c_bin_w[BW-1:0]};
    end

    // A read item addresses the store directly.
    assign rd_di_ext = (BW + DIST_W)'(r_work.distance_index);
    assign rd_addr   = {r_work.angle_index, rd_di_ext[BW-1:0]};
    assign n_rd_addr = read_issue ? rd_addr : c_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid || read_issue) begin
            r_rd_addr <= n_rd_addr;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: read the counter, then write it back incremented.
    // Neighboring steps hit different angles, so the write never meets its own read.
    logic               mem_we;
    logic [MW-1:0]      mem_wa;
    logic [COUNT_W-1:0] mem_wd;
    logic [COUNT_W-1:0] inc;

    assign inc    = (r_rd_data == COUNT_MAX) ? r_rd_data : r_rd_data + 1'b1;
    assign mem_we = sweep_on || r_d_valid;
    assign mem_wa = sweep_on ? r_sweep : r_wr_addr;
    assign mem_wd = sweep_on ? '0 : inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_rd_addr;
    end

    // Vote store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    // ------------------------------------------------------------------
    // Result of the current item.
    assign o_res.bin_count = (r_work.op == OP_READ) ? r_rd_data : '0;
    assign o_res.clipped   = r_clip;

endmodule

`default_nettype wire
